>>> rtl/psr_pkg.sv
package psr_pkg;

    localparam int CMD_W  = 4;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 16;
    localparam int FINE_W = 3;
    localparam int LAT_W  = 5;
    localparam int CNT_W  = 4;

    localparam logic [CMD_W-1:0] CMD_WCTRL   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_WSCROLL = 4'd1;
    localparam logic [CMD_W-1:0] CMD_WADDR   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_WDATA   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_WOTHER  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_RSTATUS = 4'd5;
    localparam logic [CMD_W-1:0] CMD_RDATA   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_INCX    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_INCY    = 4'd8;
    localparam logic [CMD_W-1:0] CMD_COPYX   = 4'd9;
    localparam logic [CMD_W-1:0] CMD_COPYY   = 4'd10;
    localparam logic [CMD_W-1:0] CMD_SETVB   = 4'd11;
    localparam logic [CMD_W-1:0] CMD_CLRVB   = 4'd12;
    localparam logic [CMD_W-1:0] CMD_SPR0    = 4'd13;
    localparam logic [CMD_W-1:0] CMD_OVF     = 4'd14;
    localparam logic [CMD_W-1:0] CMD_TICK    = 4'd15;

    localparam logic [CNT_W-1:0] NMI_DELAY = 4'd15;

    localparam logic [ADDR_W-1:0] MASK_KEEP_NT     = 16'hF3FF;
    localparam logic [ADDR_W-1:0] MASK_KEEP_ADDRLO = 16'h80FF;
    localparam logic [ADDR_W-1:0] MASK_KEEP_FINEY  = 16'h8FFF;
    localparam logic [ADDR_W-1:0] MASK_KEEP_ROW    = 16'hFC1F;
    localparam logic [ADDR_W-1:0] MASK_KEEP_COL    = 16'hFFE0;
    localparam logic [ADDR_W-1:0] MASK_KEEP_LOW    = 16'hFF00;
    localparam logic [ADDR_W-1:0] BIT_NT_X         = 16'h0400;
    localparam logic [ADDR_W-1:0] BIT_NT_Y         = 16'h0800;
    localparam logic [ADDR_W-1:0] MASK_V_COPYX     = 16'hFBE0;
    localparam logic [ADDR_W-1:0] MASK_T_COPYX     = 16'h041F;
    localparam logic [ADDR_W-1:0] MASK_V_COPYY     = 16'h841F;
    localparam logic [ADDR_W-1:0] MASK_T_COPYY     = 16'h7BE0;
    localparam logic [ADDR_W-1:0] FINEY_STEP       = 16'h1000;
    localparam logic [ADDR_W-1:0] ROW_STEP         = 16'h0020;
    localparam logic [ADDR_W-1:0] COL_STEP         = 16'h0001;

    localparam logic [LAT_W-1:0] ROW_LAST_VISIBLE = 5'd29;
    localparam logic [LAT_W-1:0] ROW_MAX          = 5'd31;

    typedef struct packed {
        logic [ADDR_W-1:0] access_addr;
        logic [ADDR_W-1:0] vram_addr;
        logic [FINE_W-1:0] fine_x;
        logic [BYTE_W-1:0] status_value;
        logic              nmi_pulse;
    } result_t;

endpackage

>>> rtl/ppu_scroll_address_registers_unit.sv
// Scroll-address and register core of a tile video processor (loopy v/t/x/w scheme).
// Each input word is one command; each command yields exactly one result word.
// A command is taken into an input register, applied to the state by combinational
// bit logic and its result lands in an output register; one word per cycle is sustained
// when the output side keeps up. The input side keeps accepting while a result waits,
// until both stages are full.
module ppu_scroll_address_registers_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [psr_pkg::CMD_W-1:0]     cmd,
    input  logic [psr_pkg::BYTE_W-1:0]    data_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [psr_pkg::ADDR_W-1:0]    access_addr,
    output logic [psr_pkg::ADDR_W-1:0]    vram_addr,
    output logic [psr_pkg::FINE_W-1:0]    fine_x,
    output logic [psr_pkg::BYTE_W-1:0]    status_value,
    output logic                          nmi_pulse
);

    logic                       in_valid_reg;
    logic [psr_pkg::CMD_W-1:0]  cmd_reg;
    logic [psr_pkg::BYTE_W-1:0] data_reg;
    logic                       out_valid_reg;
    psr_pkg::result_t           result_reg;
    psr_pkg::result_t           step_result;
    logic                       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    psr_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .cmd       (cmd_reg),
        .data_byte (data_reg),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg  <= cmd;
            data_reg <= data_byte;
        end
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign access_addr  = result_reg.access_addr;
    assign vram_addr    = result_reg.vram_addr;
    assign fine_x       = result_reg.fine_x;
    assign status_value = result_reg.status_value;
    assign nmi_pulse    = result_reg.nmi_pulse;

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && in_valid_reg |-> !in_ready)
        else $error("input accepted while both stages full");

    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("applied command produced no result");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("empty input stage not ready");
`endif

endmodule

>>> rtl/psr_core.sv
module psr_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic [psr_pkg::CMD_W-1:0]     cmd,
    input  logic [psr_pkg::BYTE_W-1:0]    data_byte,
    output psr_pkg::result_t              result
);

    logic [psr_pkg::ADDR_W-1:0] cur_addr_reg,      cur_addr_next;
    logic [psr_pkg::ADDR_W-1:0] temp_addr_reg,     temp_addr_next;
    logic [psr_pkg::FINE_W-1:0] fine_scroll_reg,   fine_scroll_next;
    logic                       second_write_reg,  second_write_next;
    logic                       step_by_row_reg,   step_by_row_next;
    logic                       nmi_enable_reg,    nmi_enable_next;
    logic                       vblank_reg,        vblank_next;
    logic                       nmi_prev_reg,      nmi_prev_next;
    logic [psr_pkg::CNT_W-1:0]  nmi_count_reg,     nmi_count_next;
    logic                       spr0_reg,          spr0_next;
    logic                       ovf_reg,           ovf_next;
    logic [psr_pkg::LAT_W-1:0]  last_written_reg,  last_written_next;

    logic                       nmi_check;
    logic                       nmi_level;
    logic [psr_pkg::ADDR_W-1:0] v_fine_clr;
    logic [psr_pkg::LAT_W-1:0]  row;
    logic [psr_pkg::ADDR_W-1:0] v_nt_flip;
    logic [psr_pkg::ADDR_W-1:0] t_scroll;
    logic [psr_pkg::ADDR_W-1:0] t_low;
    logic [psr_pkg::CNT_W-1:0]  count_dec;

    always_comb
    begin
        cur_addr_next     = cur_addr_reg;
        temp_addr_next    = temp_addr_reg;
        fine_scroll_next  = fine_scroll_reg;
        second_write_next = second_write_reg;
        step_by_row_next  = step_by_row_reg;
        nmi_enable_next   = nmi_enable_reg;
        vblank_next       = vblank_reg;
        spr0_next         = spr0_reg;
        ovf_next          = ovf_reg;
        last_written_next = last_written_reg;
        nmi_check         = 1'b0;
        count_dec         = nmi_count_reg - psr_pkg::CNT_W'(1);
        nmi_count_next    = nmi_count_reg;
        nmi_prev_next     = nmi_prev_reg;

        result.access_addr  = cur_addr_reg;
        result.status_value = '0;
        result.nmi_pulse    = 1'b0;

        // y increment pieces
        v_fine_clr = cur_addr_reg & psr_pkg::MASK_KEEP_FINEY;
        row        = v_fine_clr[9:5];
        v_nt_flip  = v_fine_clr;
        if (row == psr_pkg::ROW_LAST_VISIBLE)
        begin
            row       = '0;
            v_nt_flip = v_fine_clr ^ psr_pkg::BIT_NT_Y;
        end
        else if (row == psr_pkg::ROW_MAX)
        begin
            row = '0;
        end
        else
        begin
            row = row + psr_pkg::LAT_W'(1);
        end

        t_scroll = (temp_addr_reg & psr_pkg::MASK_KEEP_FINEY)
                 | {1'b0, data_byte[2:0], 12'h000};
        t_scroll = (t_scroll & psr_pkg::MASK_KEEP_ROW)
                 | {6'h00, data_byte[7:3], 5'h00};
        t_low    = (temp_addr_reg & psr_pkg::MASK_KEEP_LOW) | {8'h00, data_byte};

        if (cmd <= psr_pkg::CMD_WOTHER)
        begin
            last_written_next = data_byte[psr_pkg::LAT_W-1:0];
        end

        case (cmd)
            psr_pkg::CMD_WCTRL:
            begin
                step_by_row_next = data_byte[2];
                nmi_enable_next  = data_byte[7];
                nmi_check        = 1'b1;
                temp_addr_next   = (temp_addr_reg & psr_pkg::MASK_KEEP_NT)
                                 | {4'h0, data_byte[1:0], 10'h000};
            end
            psr_pkg::CMD_WSCROLL:
            begin
                if (!second_write_reg)
                begin
                    temp_addr_next    = (temp_addr_reg & psr_pkg::MASK_KEEP_COL)
                                      | {11'h000, data_byte[7:3]};
                    fine_scroll_next  = data_byte[2:0];
                    second_write_next = 1'b1;
                end
                else
                begin
                    temp_addr_next    = t_scroll;
                    second_write_next = 1'b0;
                end
            end
            psr_pkg::CMD_WADDR:
            begin
                if (!second_write_reg)
                begin
                    temp_addr_next    = (temp_addr_reg & psr_pkg::MASK_KEEP_ADDRLO)
                                      | {2'b00, data_byte[5:0], 8'h00};
                    second_write_next = 1'b1;
                end
                else
                begin
                    temp_addr_next    = t_low;
                    cur_addr_next     = t_low;
                    second_write_next = 1'b0;
                end
            end
            psr_pkg::CMD_WDATA,
            psr_pkg::CMD_RDATA:
            begin
                cur_addr_next = cur_addr_reg + (step_by_row_reg ? psr_pkg::ROW_STEP
                                                                : psr_pkg::COL_STEP);
            end
            psr_pkg::CMD_WOTHER:
            begin
            end
            psr_pkg::CMD_RSTATUS:
            begin
                result.status_value = {vblank_reg, spr0_reg, ovf_reg, last_written_reg};
                vblank_next         = 1'b0;
                nmi_check           = 1'b1;
                second_write_next   = 1'b0;
            end
            psr_pkg::CMD_INCX:
            begin
                if (cur_addr_reg[4:0] == 5'h1F)
                begin
                    cur_addr_next = (cur_addr_reg & psr_pkg::MASK_KEEP_COL)
                                  ^ psr_pkg::BIT_NT_X;
                end
                else
                begin
                    cur_addr_next = cur_addr_reg + psr_pkg::COL_STEP;
                end
            end
            psr_pkg::CMD_INCY:
            begin
                if (cur_addr_reg[14:12] != 3'h7)
                begin
                    cur_addr_next = cur_addr_reg + psr_pkg::FINEY_STEP;
                end
                else
                begin
                    cur_addr_next = (v_nt_flip & psr_pkg::MASK_KEEP_ROW)
                                  | {6'h00, row, 5'h00};
                end
            end
            psr_pkg::CMD_COPYX:
            begin
                cur_addr_next = (cur_addr_reg & psr_pkg::MASK_V_COPYX)
                              | (temp_addr_reg & psr_pkg::MASK_T_COPYX);
            end
            psr_pkg::CMD_COPYY:
            begin
                cur_addr_next = (cur_addr_reg & psr_pkg::MASK_V_COPYY)
                              | (temp_addr_reg & psr_pkg::MASK_T_COPYY);
            end
            psr_pkg::CMD_SETVB:
            begin
                vblank_next = 1'b1;
                nmi_check   = 1'b1;
            end
            psr_pkg::CMD_CLRVB:
            begin
                vblank_next = 1'b0;
                nmi_check   = 1'b1;
                spr0_next   = 1'b0;
                ovf_next    = 1'b0;
            end
            psr_pkg::CMD_SPR0:
            begin
                spr0_next = 1'b1;
            end
            psr_pkg::CMD_OVF:
            begin
                ovf_next = 1'b1;
            end
            default:
            begin
                if (nmi_count_reg != '0)
                begin
                    nmi_count_next   = count_dec;
                    result.nmi_pulse = (count_dec == '0) && nmi_enable_reg && vblank_reg;
                end
            end
        endcase

        // nmi edge detect on enable/vblank change
        nmi_level = nmi_enable_next & vblank_next;
        if (nmi_check)
        begin
            if (nmi_level && !nmi_prev_reg)
            begin
                nmi_count_next = psr_pkg::NMI_DELAY;
            end
            nmi_prev_next = nmi_level;
        end

        result.vram_addr = cur_addr_next;
        result.fine_x    = fine_scroll_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_addr_reg     <= '0;
            temp_addr_reg    <= '0;
            fine_scroll_reg  <= '0;
            second_write_reg <= 1'b0;
            step_by_row_reg  <= 1'b0;
            nmi_enable_reg   <= 1'b0;
            vblank_reg       <= 1'b0;
            nmi_prev_reg     <= 1'b0;
            nmi_count_reg    <= '0;
            spr0_reg         <= 1'b0;
            ovf_reg          <= 1'b0;
            last_written_reg <= '0;
        end
        else if (step_en)
        begin
            cur_addr_reg     <= cur_addr_next;
            temp_addr_reg    <= temp_addr_next;
            fine_scroll_reg  <= fine_scroll_next;
            second_write_reg <= second_write_next;
            step_by_row_reg  <= step_by_row_next;
            nmi_enable_reg   <= nmi_enable_next;
            vblank_reg       <= vblank_next;
            nmi_prev_reg     <= nmi_prev_next;
            nmi_count_reg    <= nmi_count_next;
            spr0_reg         <= spr0_next;
            ovf_reg          <= ovf_next;
            last_written_reg <= last_written_next;
        end
    end

`ifndef ASSERT_OFF
    a_pulse_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && result.nmi_pulse |-> nmi_count_reg == psr_pkg::CNT_W'(1))
        else $error("nmi pulse without countdown expiring");

    a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && cmd == psr_pkg::CMD_RSTATUS |=> !vblank_reg && !second_write_reg)
        else $error("status read did not clear vblank and toggle");

    a_addr_load: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && cmd == psr_pkg::CMD_WADDR && second_write_reg
        |=> cur_addr_reg == temp_addr_reg)
        else $error("second address write did not load v from t");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd != psr_pkg::CMD_RSTATUS |-> result.status_value == '0)
        else $error("status byte driven outside status read");
`endif

endmodule
